/* design/ole_pkg.sv */
package ole_pkg;

    localparam int FUNC_W         = 3;
    localparam int POS_W          = 7;
    localparam int VALUE_W        = 32;
    localparam int ITEM_W         = 7;
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [FUNC_W-1:0] {
        F_INSERT  = 3'd0,
        F_APPEND  = 3'd1,
        F_DEL_POS = 3'd2,
        F_POP     = 3'd3,
        F_DEL_VAL = 3'd4,
        F_SEARCH  = 3'd5,
        F_UPDATE  = 3'd6,
        F_READ    = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t                    status;
        logic                       found;
        logic signed [VALUE_W-1:0]  read_value;
        logic [ITEM_W-1:0]          item_count;
        logic                       is_empty;
    } res_t;

endpackage

/* design/ordered_list_engine_unit.sv */
// Requests are handled one at a time: pop, update and failed requests finish in S_IDLE, a read
// passes through S_READ, insert and append walk the entries from the tail down in S_SHIFT,
// and delete and search scan from the start position (0 for delete by value and search) in S_SCAN.
// Each walk is set by the single memory port pair moving one entry per cycle. Reset: rst_n
// clears the count, the sequencer state, its pending-read flag and the output valid flag
// asynchronously; entries are not cleared.
module ordered_list_engine_unit import ole_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [FUNC_W-1:0]          func,
    input  logic [POS_W-1:0]           position,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic                       found,
    output logic signed [VALUE_W-1:0]  read_value,
    output logic [ITEM_W-1:0]          item_count,
    output logic                       is_empty
);

    localparam int AW = $clog2(CAPACITY);

    res_t                  res;
    logic                  res_valid;
    logic                  res_take;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    res_t out_res_reg, out_res_next;
    logic out_valid_reg, out_valid_next;

    ole_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ole_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .position  (position),
        .value     (value),
        .res       (res),
        .res_valid (res_valid),
        .res_take  (res_take),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // The output word register frees the sequencer as soon as it can load.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_res_next   = res;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign found      = out_res_reg.found;
    assign read_value = out_res_reg.read_value;
    assign item_count = out_res_reg.item_count;
    assign is_empty   = out_res_reg.is_empty;

endmodule

/* design/ole_ram.sv */
module ole_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ole_seq.sv */
module ole_seq import ole_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [FUNC_W-1:0]               func,
    input  logic [POS_W-1:0]                position,
    input  logic signed [VALUE_W-1:0]       value,
    output res_t                            res,
    output logic                            res_valid,
    input  logic                            res_take,
    output logic                            mem_we,
    output logic [$clog2(CAPACITY)-1:0]     mem_waddr,
    output logic [DATA_WIDTH-1:0]           mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]     mem_raddr,
    input  logic [DATA_WIDTH-1:0]           mem_rdata
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PXW = (CW > POS_W) ? CW : POS_W;

    state_t                    state_reg, state_next;
    func_t                     op_reg, op_next;
    logic [PXW-1:0]            pos_reg, pos_next;
    logic [DATA_WIDTH-1:0]     data_reg, data_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             rd_idx_reg, rd_idx_next;
    logic [CW-1:0]             wr_idx_reg, wr_idx_next;
    logic [CW-1:0]             tag_reg, tag_next;
    logic                      pend_reg, pend_next;
    status_t                   status_reg, status_next;
    logic                      found_reg, found_next;
    logic signed [VALUE_W-1:0] rdval_reg, rdval_next;

    logic [PXW-1:0]        pos_x;
    logic [PXW-1:0]        cnt_x;
    logic [DATA_WIDTH-1:0] in_data;
    logic                  full;
    logic                  empty;
    logic                  hit;
    logic                  keep;
    logic [CW-1:0]         tag_inc;
    logic [CW-1:0]         rd_inc;
    logic [CW-1:0]         rd_dec;
    logic [CW-1:0]         wr_inc;

    assign pos_x   = PXW'(position);
    assign cnt_x   = PXW'(count_reg);
    assign in_data = DATA_WIDTH'(value);
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign hit     = (mem_rdata == data_reg);
    assign keep    = (op_reg == F_DEL_VAL) ? !hit : (PXW'(tag_reg) != pos_reg);
    assign tag_inc = tag_reg + CW'(1);
    assign rd_inc  = rd_idx_reg + CW'(1);
    assign rd_dec  = rd_idx_reg - CW'(1);
    assign wr_inc  = wr_idx_reg + CW'(1);

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status     = status_reg;
    assign res.found      = found_reg;
    assign res.read_value = rdval_reg;
    assign res.item_count = ITEM_W'(count_reg);
    assign res.is_empty   = empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        data_reg   <= data_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rdval_reg  <= rdval_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        data_next   = data_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        tag_next    = tag_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rdval_next  = rdval_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = data_reg;
        mem_raddr   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // A read request fetches its entry right away; the word lands in S_READ.
                mem_raddr = pos_x[AW-1:0];
                if (in_valid)
                begin
                    op_next     = func_t'(func);
                    pos_next    = pos_x;
                    data_next   = in_data;
                    found_next  = 1'b0;
                    rdval_next  = '0;
                    status_next = ST_OK;
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                    unique case (func_t'(func))
                        F_INSERT:
                        begin
                            if (pos_x > cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                rd_idx_next = count_reg;
                                state_next  = S_SHIFT;
                            end
                        end
                        F_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next    = cnt_x;
                                rd_idx_next = count_reg;
                                state_next  = S_SHIFT;
                            end
                        end
                        F_DEL_POS:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_idx_next = CW'(pos_x);
                                wr_idx_next = CW'(pos_x);
                                state_next  = S_SCAN;
                            end
                        end
                        F_POP:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        F_DEL_VAL:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                wr_idx_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        F_SEARCH:
                        begin
                            rd_idx_next = '0;
                            wr_idx_next = '0;
                            state_next  = S_SCAN;
                        end
                        F_UPDATE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_x[AW-1:0];
                                mem_wdata = in_data;
                            end
                        end
                        F_READ:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // Walk down from the tail; each word read is written one slot up in the cycle after its read.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tag_inc[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (PXW'(rd_idx_reg) > pos_reg)
                begin
                    mem_raddr   = rd_dec[AW-1:0];
                    tag_next    = rd_dec;
                    rd_idx_next = rd_dec;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = pos_reg[AW-1:0];
                        mem_wdata  = data_reg;
                        count_next = count_reg + CW'(1);
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                // Compaction: kept words are written at the write index, which never
                // passes the read index, so no unread entry is overwritten.
                if (pend_reg)
                begin
                    if (op_reg == F_SEARCH)
                    begin
                        if (hit)
                        begin
                            found_next = 1'b1;
                        end
                    end
                    else if (keep)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = wr_idx_reg[AW-1:0];
                        mem_wdata   = mem_rdata;
                        wr_idx_next = wr_inc;
                    end
                end
                if (rd_idx_reg < count_reg)
                begin
                    mem_raddr   = rd_idx_reg[AW-1:0];
                    tag_next    = rd_idx_reg;
                    rd_idx_next = rd_inc;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (op_reg != F_SEARCH)
                        begin
                            count_next = wr_idx_reg;
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_READ:
            begin
                rdval_next = VALUE_W'($signed(mem_rdata));
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_waddr) <= count_reg))
        else $error("memory write beyond the list tail");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (wr_idx_reg <= rd_idx_reg))
        else $error("compaction write index passed read index");

    a_pend_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SHIFT || state_reg == S_SCAN))
        else $error("outstanding read outside a list walk");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !res_take) |=> (state_reg == S_DONE && $stable(count_reg)))
        else $error("result dropped before it was taken");

endmodule

/* tb/sv/ordered_list_engine_unit_test.sv */
module ordered_list_engine_unit_test;
    import ole_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [FUNC_W-1:0]         func = '0;
    logic [POS_W-1:0]          position = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_stall;
    logic [1:0]                status;
    logic                      found;
    logic signed [VALUE_W-1:0] read_value;
    logic [ITEM_W-1:0]         item_count;
    logic                      is_empty;

    always #5 clk = ~clk;

    ordered_list_engine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .found      (found),
        .read_value (read_value),
        .item_count (item_count),
        .is_empty   (is_empty)
    );

    logic signed [VALUE_W-1:0] model_list[$];
    res_t                      pending_results[$];
    int                        errors = 0;
    int                        send_idle_pct = 0;
    int                        stall_pct = 0;
    int                        hold_left = 0;

    // Applies one request to the list copy and returns the result word it must give.
    function automatic res_t apply_list_op(func_t op, int pos, logic signed [VALUE_W-1:0] val);
        res_t                      r;
        int                        cnt;
        logic signed [VALUE_W-1:0] kept[$];
        r = '0;
        r.status = ST_OK;
        cnt = model_list.size();
        case (op)
            F_INSERT:
                if (pos > cnt) r.status = ST_RANGE;
                else if (cnt >= LIST_CAP) r.status = ST_FULL;
                else model_list.insert(pos, val);
            F_APPEND:
                if (cnt >= LIST_CAP) r.status = ST_FULL;
                else model_list.push_back(val);
            F_DEL_POS:
                if (cnt == 0) r.status = ST_EMPTY;
                else if (pos >= cnt) r.status = ST_RANGE;
                else model_list.delete(pos);
            F_POP:
                if (cnt == 0) r.status = ST_EMPTY;
                else void'(model_list.pop_back());
            F_DEL_VAL:
                if (cnt == 0) r.status = ST_EMPTY;
                else
                begin
                    foreach (model_list[i])
                        if (model_list[i] != val) kept.push_back(model_list[i]);
                    model_list = kept;
                end
            F_SEARCH:
                foreach (model_list[i])
                    if (model_list[i] == val) r.found = 1'b1;
            F_UPDATE:
                if (pos >= cnt) r.status = ST_RANGE;
                else model_list[pos] = val;
            default:
                if (pos >= cnt) r.status = ST_RANGE;
                else r.read_value = model_list[pos];
        endcase
        r.item_count = ITEM_W'(model_list.size());
        r.is_empty = (model_list.size() == 0);
        return r;
    endfunction

    task automatic send_word(func_t op, int pos, logic signed [VALUE_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            func = FUNC_W'($urandom);
            position = POS_W'($urandom);
            value = VALUE_W'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        func = op;
        position = pos[POS_W-1:0];
        value = val;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_results.push_back(apply_list_op(op, pos % 128, val));
    endtask

    task automatic send_random_word();
        int                        r;
        int                        cnt;
        int                        pos;
        func_t                     op;
        logic signed [VALUE_W-1:0] val;
        cnt = model_list.size();
        r = $urandom_range(99);
        if (r < 20) op = F_INSERT;
        else if (r < 35) op = F_APPEND;
        else if (r < 45) op = F_DEL_POS;
        else if (r < 52) op = F_POP;
        else if (r < 58) op = F_DEL_VAL;
        else if (r < 72) op = F_SEARCH;
        else if (r < 84) op = F_UPDATE;
        else op = F_READ;
        r = $urandom_range(99);
        if (r < 75) pos = $urandom_range(cnt);
        else if (r < 85) pos = cnt + $urandom_range(1);
        else pos = $urandom_range(127);
        // A small pool of values makes duplicates, so searches and deletes by value hit.
        r = $urandom_range(99);
        if (r < 60) val = $signed($urandom_range(15)) - 8;
        else if (r < 80 && cnt > 0) val = model_list[$urandom_range(cnt - 1)];
        else if (r < 85) val = ($urandom_range(1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        else val = $urandom;
        send_word(op, pos, val);
    endtask

    task automatic test_edge_cases();
        send_word(F_POP, 0, 0);
        send_word(F_DEL_POS, 0, 0);
        send_word(F_DEL_VAL, 0, 5);
        send_word(F_SEARCH, 0, 5);
        send_word(F_UPDATE, 0, 1);
        send_word(F_READ, 0, 0);
        send_word(F_INSERT, 1, 7);
        send_word(F_INSERT, 0, 32'sh7fffffff);
        send_word(F_APPEND, 127, 32'sh80000000);
        send_word(F_INSERT, 1, -1);
        send_word(F_INSERT, 3, -1);
        send_word(F_INSERT, 127, 3);
        for (int i = 0; i <= 4; i++) send_word(F_READ, i, 0);
        send_word(F_SEARCH, 0, -1);
        send_word(F_SEARCH, 0, 0);
        send_word(F_UPDATE, 2, 0);
        send_word(F_UPDATE, 127, 0);
        send_word(F_DEL_VAL, 0, 9);
        send_word(F_DEL_VAL, 0, -1);
        send_word(F_DEL_POS, 127, 0);
        send_word(F_DEL_POS, 0, 0);
        send_word(F_READ, 0, 0);
    endtask

    task automatic test_capacity();
        int cnt;
        while (model_list.size() < LIST_CAP)
        begin
            if ($urandom_range(3) == 0)
                send_word(F_INSERT, $urandom_range(model_list.size()), $urandom);
            else
                send_word(F_APPEND, $urandom_range(127), $urandom);
        end
        cnt = model_list.size();
        send_word(F_APPEND, 0, 1);
        send_word(F_INSERT, cnt, 1);
        send_word(F_INSERT, 0, 1);
        send_word(F_INSERT, cnt + 1, 1);
        send_word(F_READ, cnt - 1, 0);
        send_word(F_READ, cnt, 0);
        send_word(F_UPDATE, cnt - 1, 32'sh80000000);
        send_word(F_SEARCH, 0, 32'sh80000000);
        send_word(F_DEL_POS, cnt - 1, 0);
        while (model_list.size() > 0)
        begin
            if ($urandom_range(1) == 0) send_word(F_POP, 0, 0);
            else send_word(F_DEL_POS, $urandom_range(model_list.size() - 1), 0);
        end
        send_word(F_POP, 0, 0);
        send_word(F_DEL_VAL, 0, 0);
    endtask

    task automatic test_random_phase(int n, int sender_idle, int receiver_stall);
        send_idle_pct = sender_idle;
        stall_pct = receiver_stall;
        repeat (n) send_random_word();
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the
    // block fills up and has to stall its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        repeat (12) send_random_word();
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_result
        res_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected, expected nothing, %s %0d %s %0d",
                         $time, "actual status", status, "count", item_count);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("found", 32'(want.found), 32'(found));
                check_field("read_value", want.read_value, read_value);
                check_field("item_count", 32'(want.item_count), 32'(item_count));
                check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
            end
        end
    end

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_edge_cases();
        test_capacity();
        test_random_phase(150, 0, 0);
        test_random_phase(150, 64, 0);
        test_backpressure();
        test_random_phase(150, 0, 64);
        test_random_phase(150, 23, 23);
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
design/ole_pkg.sv
design/ole_ram.sv
design/ole_seq.sv
design/ordered_list_engine_unit.sv
tb/sv/ordered_list_engine_unit_test.sv
